// File: src/summed_area_table_macros.svh
// ---------------------------------------------------------------------------
// Summed-area table assertion macros
// Shared property shapes for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef SUMMED_AREA_TABLE_MACROS_SVH
`define SUMMED_AREA_TABLE_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define SAT_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define SAT_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// File: src/sat_pkg.sv
// ---------------------------------------------------------------------------
// Summed-area table package
// Sizes, command and status codes, and the records passed between modules.
// ---------------------------------------------------------------------------
package sat_pkg;

   localparam int MAX_ROWS     = 64;
   localparam int MAX_COLS     = 64;
   localparam int ELEMENT_BITS = 32;
   localparam int SUM_BITS     = 44;
   localparam int CORNER_BITS  = 6;
   localparam int CFG_BITS     = 7;
   localparam int CMD_BITS     = 2;
   localparam int STATUS_BITS  = 2;
   localparam int CSR_INDEX_BITS = 1;

   localparam int ROW_BITS     = $clog2(MAX_ROWS);
   localparam int COL_BITS     = $clog2(MAX_COLS);
   localparam int ROW_CNT_BITS = $clog2(MAX_ROWS + 1);
   localparam int COL_CNT_BITS = $clog2(MAX_COLS + 1);
   localparam int ADDR_BITS    = ROW_BITS + COL_BITS;

   localparam int QUERY_READS  = 4;
   localparam int STEP_BITS    = $clog2(QUERY_READS + 1);

   localparam int ROWS_RESET   = (64 > MAX_ROWS) ? MAX_ROWS : 64;
   localparam int COLS_RESET   = (64 > MAX_COLS) ? MAX_COLS : 64;

   localparam logic [CMD_BITS-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_QUERY   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_RESTART = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_CORNER = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_INCOMPLETE = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL       = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ROWS_IN_USE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COLS_IN_USE = 1'b1;

   typedef struct packed {
      logic [ROW_CNT_BITS-1:0] rows_in_use;
      logic [COL_CNT_BITS-1:0] cols_in_use;
      logic                    restart;
   } sat_cfg_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      logic [SUM_BITS-1:0]  wr_data;
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
   } sat_mem_req_type;

endpackage

// File: src/sat_req_if.sv
// ---------------------------------------------------------------------------
// Summed-area table request channel
// Valid/ready channel carrying a command with its element and query corners.
// ---------------------------------------------------------------------------
interface sat_req_if;
   import sat_pkg::*;

   logic                           valid;
   logic                           ready;
   logic [CMD_BITS-1:0]            cmd;
   logic signed [ELEMENT_BITS-1:0] element;
   logic [CORNER_BITS-1:0]         top_row;
   logic [CORNER_BITS-1:0]         left_col;
   logic [CORNER_BITS-1:0]         bottom_row;
   logic [CORNER_BITS-1:0]         right_col;

   modport source (
      output valid, cmd, element, top_row, left_col, bottom_row, right_col,
      input  ready
   );

   modport sink (
      input  valid, cmd, element, top_row, left_col, bottom_row, right_col,
      output ready
   );

endinterface

// File: src/sat_rsp_if.sv
// ---------------------------------------------------------------------------
// Summed-area table response channel
// Valid/ready channel carrying the rectangle sum and a status code.
// ---------------------------------------------------------------------------
interface sat_rsp_if;
   import sat_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SUM_BITS-1:0] region_sum;
   logic [STATUS_BITS-1:0]     status;

   modport source (
      output valid, region_sum, status,
      input  ready
   );

   modport sink (
      input  valid, region_sum, status,
      output ready
   );

endinterface

// File: src/sat_table.sv
// ---------------------------------------------------------------------------
// Summed-area table storage
// Prefix-sum memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module sat_table (
   input  logic                          clock,
   input  sat_pkg::sat_mem_req_type      mem_req,
   output logic [sat_pkg::SUM_BITS-1:0]  rd_data
);
   import sat_pkg::*;

   logic [SUM_BITS-1:0] mem [2**ADDR_BITS];
   logic [SUM_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/sat_seq.sv
// ---------------------------------------------------------------------------
// Summed-area table sequencer
// Runs loads and queries against the table memory and holds the result.
// ---------------------------------------------------------------------------
module sat_seq (
   input  logic                          clock,
   input  logic                          reset,
   sat_req_if.sink                       req,
   sat_rsp_if.source                     rsp,
   input  sat_pkg::sat_cfg_type          cfg,
   output sat_pkg::sat_mem_req_type      mem_req,
   input  logic [sat_pkg::SUM_BITS-1:0]  mem_rd_data
);
   import sat_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_LOAD, S_QUERY, S_DONE} state_type;

   state_type               state_ff, state_in;
   logic [ROW_CNT_BITS-1:0] load_row_ff, load_row_in;
   logic [COL_BITS-1:0]     load_col_ff, load_col_in;
   logic [SUM_BITS-1:0]     run_ff, run_in;
   logic [CORNER_BITS-1:0]  top_ff, top_in;
   logic [CORNER_BITS-1:0]  left_ff, left_in;
   logic [CORNER_BITS-1:0]  bottom_ff, bottom_in;
   logic [CORNER_BITS-1:0]  right_ff, right_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;
   logic [SUM_BITS-1:0]     acc_ff, acc_in;
   logic [SUM_BITS-1:0]     res_sum_ff, res_sum_in;
   logic [STATUS_BITS-1:0]  res_status_ff, res_status_in;
   logic                    out_valid_ff, out_valid_in;
   logic [SUM_BITS-1:0]     out_sum_ff, out_sum_in;
   logic [STATUS_BITS-1:0]  out_status_ff, out_status_in;

   logic                    complete;
   logic                    bad_corners;
   logic [COL_CNT_BITS-1:0] col_next;
   logic [SUM_BITS-1:0]     above;
   logic [ROW_BITS-1:0]     q_row;
   logic [COL_BITS-1:0]     q_col;
   logic [1:0]              term;
   logic                    term_en;
   logic                    term_sub;

   assign complete = load_row_ff >= cfg.rows_in_use;
   assign bad_corners = (req.top_row > req.bottom_row) || (req.left_col > req.right_col)
                     || (32'(req.bottom_row) >= 32'(cfg.rows_in_use))
                     || (32'(req.right_col) >= 32'(cfg.cols_in_use));
   assign col_next = COL_CNT_BITS'(load_col_ff) + COL_CNT_BITS'(1);
   assign above = (load_row_ff == '0) ? '0 : mem_rd_data;
   assign term = 2'(step_ff - STEP_BITS'(1));

   // Corner reads: bottom-right, top-right, bottom-left, top-left, where the
   // top and left neighbours sit one row above and one column left.
   always_comb begin
      case (step_ff[1:0])
         2'd0: begin
            q_row = ROW_BITS'(bottom_ff);
            q_col = COL_BITS'(right_ff);
         end
         2'd1: begin
            q_row = ROW_BITS'(top_ff - CORNER_BITS'(1));
            q_col = COL_BITS'(right_ff);
         end
         2'd2: begin
            q_row = ROW_BITS'(bottom_ff);
            q_col = COL_BITS'(left_ff - CORNER_BITS'(1));
         end
         default: begin
            q_row = ROW_BITS'(top_ff - CORNER_BITS'(1));
            q_col = COL_BITS'(left_ff - CORNER_BITS'(1));
         end
      endcase
   end

   // Terms that fall on the zero border are skipped.
   always_comb begin
      case (term)
         2'd0: begin
            term_en  = 1'b1;
            term_sub = 1'b0;
         end
         2'd1: begin
            term_en  = top_ff != '0;
            term_sub = 1'b1;
         end
         2'd2: begin
            term_en  = left_ff != '0;
            term_sub = 1'b1;
         end
         default: begin
            term_en  = (top_ff != '0) && (left_ff != '0);
            term_sub = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      load_row_in   = load_row_ff;
      load_col_in   = load_col_ff;
      run_in        = run_ff;
      top_in        = top_ff;
      left_in       = left_ff;
      bottom_in     = bottom_ff;
      right_in      = right_ff;
      step_in       = step_ff;
      acc_in        = acc_ff;
      res_sum_in    = res_sum_ff;
      res_status_in = res_status_ff;
      out_valid_in  = out_valid_ff;
      out_sum_in    = out_sum_ff;
      out_status_in = out_status_ff;
      mem_req       = '0;

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               res_sum_in    = '0;
               res_status_in = STATUS_OK;
               state_in      = S_DONE;
               case (req.cmd)
                  CMD_LOAD: begin
                     if (complete) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        run_in          = run_ff + SUM_BITS'(req.element);
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = {ROW_BITS'(load_row_ff - ROW_CNT_BITS'(1)),
                                           load_col_ff};
                        state_in        = S_LOAD;
                     end
                  end
                  CMD_QUERY: begin
                     top_in    = req.top_row;
                     left_in   = req.left_col;
                     bottom_in = req.bottom_row;
                     right_in  = req.right_col;
                     if (!complete) begin
                        res_status_in = STATUS_INCOMPLETE;
                     end else if (bad_corners) begin
                        res_status_in = STATUS_BAD_CORNER;
                     end else begin
                        step_in  = '0;
                        acc_in   = '0;
                        state_in = S_QUERY;
                     end
                  end
                  CMD_RESTART: begin
                     load_row_in = '0;
                     load_col_in = '0;
                     run_in      = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LOAD: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = {ROW_BITS'(load_row_ff), load_col_ff};
            mem_req.wr_data = run_ff + above;
            if (col_next >= cfg.cols_in_use) begin
               load_col_in = '0;
               load_row_in = load_row_ff + ROW_CNT_BITS'(1);
               run_in      = '0;
            end else begin
               load_col_in = COL_BITS'(col_next);
            end
            state_in = S_DONE;
         end
         S_QUERY: begin
            if (step_ff != STEP_BITS'(QUERY_READS)) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = {q_row, q_col};
            end
            if (step_ff != '0 && term_en) begin
               acc_in = term_sub ? acc_ff - mem_rd_data : acc_ff + mem_rd_data;
            end
            if (step_ff == STEP_BITS'(QUERY_READS)) begin
               res_sum_in = acc_in;
               state_in   = S_DONE;
            end
            step_in = step_ff + STEP_BITS'(1);
         end
         S_DONE: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in  = 1'b1;
               out_sum_in    = res_sum_ff;
               out_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A register write starts a new load.
      if (cfg.restart) begin
         load_row_in = '0;
         load_col_in = '0;
         run_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         load_row_ff  <= '0;
         load_col_ff  <= '0;
         run_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_row_ff  <= load_row_in;
         load_col_ff  <= load_col_in;
         run_ff       <= run_in;
         out_valid_ff <= out_valid_in;
      end
      top_ff        <= top_in;
      left_ff       <= left_in;
      bottom_ff     <= bottom_in;
      right_ff      <= right_in;
      step_ff       <= step_in;
      acc_ff        <= acc_in;
      res_sum_ff    <= res_sum_in;
      res_status_ff <= res_status_in;
      out_sum_ff    <= out_sum_in;
      out_status_ff <= out_status_in;
   end

   assign req.ready      = state_ff == S_IDLE;
   assign rsp.valid      = out_valid_ff;
   assign rsp.region_sum = out_sum_ff;
   assign rsp.status     = out_status_ff;

endmodule

// File: src/summed_area_table.sv
// ---------------------------------------------------------------------------
// Summed-area table
// Builds an integral image from a row-major element stream and answers
// inclusive rectangle-sum queries from it.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Transfer when              Carries
//   req_chan  in         valid && ready             cmd, element, four corners
//   rsp_chan  out        valid && ready             region_sum, status
//   csr_*     in         csr_write_enable           register index and value
//
// A load passes the load state and a query with good corners the query state,
// both owing to the single read port of the table memory; others skip to done.
// The result sits in an output register, so the next request is taken while
// an earlier result still waits for its transfer; a stall holds it there.
// Reset is synchronous; the table itself is not cleared, since
// every entry is written by a load before any query reads it.
//
`include "summed_area_table_macros.svh"

module summed_area_table (
   input  logic                                clock,
   input  logic                                reset,
   sat_req_if.sink                             req_chan,
   sat_rsp_if.source                           rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [sat_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sat_pkg::CFG_BITS-1:0]        csr_write_data
);
   import sat_pkg::*;

   // Configuration registers hold the sizes already clamped to 1..maximum,
   // so the sequencer never sees a zero or oversized dimension.
   logic [ROW_CNT_BITS-1:0] rows_ff, rows_in;
   logic [COL_CNT_BITS-1:0] cols_ff, cols_in;
   logic [ROW_CNT_BITS-1:0] rows_clamped;
   logic [COL_CNT_BITS-1:0] cols_clamped;

   sat_cfg_type             cfg;
   sat_mem_req_type         mem_req;
   logic [SUM_BITS-1:0]     mem_rd_data;

   // Terms used by the checks at the end of the module.
   logic                    sizes_legal;
   logic                    rsp_flagged;
   logic                    rsp_sum_zero;
   logic                    load_only;
   logic                    req_xfer;
   logic                    seq_busy;

   always_comb begin
      if (csr_write_data == '0) begin
         rows_clamped = ROW_CNT_BITS'(1);
      end else if (32'(csr_write_data) > MAX_ROWS) begin
         rows_clamped = ROW_CNT_BITS'(MAX_ROWS);
      end else begin
         rows_clamped = ROW_CNT_BITS'(csr_write_data);
      end

      if (csr_write_data == '0) begin
         cols_clamped = COL_CNT_BITS'(1);
      end else if (32'(csr_write_data) > MAX_COLS) begin
         cols_clamped = COL_CNT_BITS'(MAX_COLS);
      end else begin
         cols_clamped = COL_CNT_BITS'(csr_write_data);
      end

      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_ROWS_IN_USE: rows_in = rows_clamped;
            REG_COLS_IN_USE: cols_in = cols_clamped;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROW_CNT_BITS'(ROWS_RESET);
         cols_ff <= COL_CNT_BITS'(COLS_RESET);
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   // Any register write also sends the load position back to the start.
   assign cfg.rows_in_use = rows_ff;
   assign cfg.cols_in_use = cols_ff;
   assign cfg.restart     = csr_write_enable;

   sat_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .cfg         (cfg),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

   sat_table u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   assign sizes_legal  = (rows_ff != '0) && (cols_ff != '0)
                      && (32'(rows_ff) <= MAX_ROWS) && (32'(cols_ff) <= MAX_COLS);
   assign rsp_flagged  = rsp_chan.valid && (rsp_chan.status != STATUS_OK);
   assign rsp_sum_zero = rsp_chan.region_sum == '0;
   assign load_only    = !req_chan.ready && !mem_req.rd_en;
   assign req_xfer     = req_chan.valid && req_chan.ready;
   assign seq_busy     = !req_chan.ready;

   // The clamped sizes never leave their legal range.
   `SAT_ASSERT_NOW(a_sizes_legal, clock, reset, 1'b1, sizes_legal, "table size out of range")

   // Flagged commands return a zero sum, as do all non-queries; only flagged ones are checked here.
   `SAT_ASSERT_NOW(a_flag_zero, clock, reset, rsp_flagged, rsp_sum_zero, "flagged sum not zero")

   // A table write only happens while a load is in flight, never when idle.
   `SAT_ASSERT_NOW(a_write_busy, clock, reset, mem_req.wr_en, load_only, "write outside a load")

   // Taking a request always engages the sequencer on the next cycle.
   `SAT_ASSERT_NEXT(a_accept_busy, clock, reset, req_xfer, seq_busy, "idle after a transfer")

endmodule

// File: sim/summed_area_table_checker.sv
// ---------------------------------------------------------------------------
// Summed-area table checker
// Watches the request, response and register ports, keeps its own copy of
// the integral image, and compares every response with its prediction.
// ---------------------------------------------------------------------------
module summed_area_table_checker (
   input  logic                               clock,
   input  logic                               reset,
   sat_req_if                                 req_chan,
   sat_rsp_if                                 rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [sat_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sat_pkg::CFG_BITS-1:0]       csr_write_data,
   output int unsigned                        error_count,
   output int unsigned                        results_pending,
   output int unsigned                        results_checked
);
   import sat_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef logic [SUM_BITS-1:0] area_sum_type;

   typedef struct packed {
      area_sum_type           region_sum;
      logic [STATUS_BITS-1:0] status;
   } area_result_type;

   area_sum_type    integral [MAX_ROWS*MAX_COLS];
   area_sum_type    row_total;
   int unsigned     fill_row;
   int unsigned     fill_col;
   int unsigned     shape_rows;
   int unsigned     shape_cols;
   area_result_type expected_results [$];
   int unsigned     mismatches;
   int unsigned     compared;

   function automatic int unsigned clamp_extent(logic [CFG_BITS-1:0] raw,
                                                int unsigned limit);
      if (raw == '0) return 1;
      if (32'(raw) > limit) return limit;
      return 32'(raw);
   endfunction

   // Rows and columns counted from one; row or column zero is the zero border.
   function automatic area_sum_type integral_at(int unsigned row, int unsigned col);
      if (row == 0 || col == 0) return '0;
      return integral[(row - 1) * MAX_COLS + (col - 1)];
   endfunction

   function automatic void restart_fill();
      row_total = '0;
      fill_row  = 0;
      fill_col  = 0;
   endfunction

   function automatic area_result_type predict_request(
      logic [CMD_BITS-1:0]     cmd,
      logic [ELEMENT_BITS-1:0] element,
      int unsigned             top_row,
      int unsigned             left_col,
      int unsigned             bottom_row,
      int unsigned             right_col
   );
      area_result_type res;
      logic            complete;
      res.region_sum = '0;
      res.status     = STATUS_OK;
      complete       = (fill_row >= shape_rows);
      case (cmd)
         CMD_LOAD: begin
            if (complete) begin
               res.status = STATUS_FULL;
            end else begin
               row_total = row_total
                         + {{(SUM_BITS-ELEMENT_BITS){element[ELEMENT_BITS-1]}}, element};
               integral[fill_row * MAX_COLS + fill_col] =
                  row_total + integral_at(fill_row, fill_col + 1);
               fill_col++;
               if (fill_col >= shape_cols) begin
                  fill_col  = 0;
                  fill_row++;
                  row_total = '0;
               end
            end
         end
         CMD_QUERY: begin
            if (!complete) begin
               res.status = STATUS_INCOMPLETE;
            end else if (top_row > bottom_row || left_col > right_col
                         || bottom_row >= shape_rows || right_col >= shape_cols) begin
               res.status = STATUS_BAD_CORNER;
            end else begin
               res.region_sum = integral_at(bottom_row + 1, right_col + 1)
                              - integral_at(top_row, right_col + 1)
                              - integral_at(bottom_row + 1, left_col)
                              + integral_at(top_row, left_col);
            end
         end
         CMD_RESTART: restart_fill();
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      area_result_type want;
      if (reset) begin
         restart_fill();
         shape_rows = ROWS_RESET;
         shape_cols = COLS_RESET;
         expected_results.delete();
      end else begin
         // Responses first: a request is never answered in the cycle it is taken.
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: response with none expected: sum %0d status %0d",
                           $time, rsp_chan.region_sum, rsp_chan.status);
            end else begin
               want = expected_results.pop_front();
               compared++;
               if (rsp_chan.region_sum !== want.region_sum
                   || rsp_chan.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("%0t: response %0d expected sum %0d status %0d, got %0d status %0d",
                              $time, compared, $signed(want.region_sum), want.status,
                              rsp_chan.region_sum, rsp_chan.status);
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            expected_results.push_back(predict_request(
               req_chan.cmd, req_chan.element,
               32'(req_chan.top_row), 32'(req_chan.left_col),
               32'(req_chan.bottom_row), 32'(req_chan.right_col)));
         if (csr_write_enable) begin
            if (csr_index == REG_ROWS_IN_USE)
               shape_rows = clamp_extent(csr_write_data, MAX_ROWS);
            else
               shape_cols = clamp_extent(csr_write_data, MAX_COLS);
            restart_fill();
         end
      end
      error_count     <= mismatches;
      results_pending <= expected_results.size();
      results_checked <= compared;
   end

endmodule

// File: sim/summed_area_table_tb.sv
// ---------------------------------------------------------------------------
// Summed-area table testbench
// Drives loads, rectangle queries and restarts over many table shapes, with
// random gaps on the request side and random stalls on the response side.
// A checker beside the block predicts every response and counts mismatches.
// ---------------------------------------------------------------------------
module summed_area_table_tb;
   import sat_pkg::*;

   // Command code 3 has no meaning; the block must answer it as a no-op.
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS   = 1450;
   localparam int SETTLE_CYCLES  = 8;     // a little over the slowest query
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 2000;  // far above the longest gap plus stall

   typedef struct packed {
      logic [CMD_BITS-1:0]     cmd;
      logic [ELEMENT_BITS-1:0] element;
      logic [CORNER_BITS-1:0]  top_row;
      logic [CORNER_BITS-1:0]  left_col;
      logic [CORNER_BITS-1:0]  bottom_row;
      logic [CORNER_BITS-1:0]  right_col;
   } area_request_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]       csr_write_data;

   int unsigned error_count;
   int unsigned results_pending;
   int unsigned results_checked;

   // Effective table shape, as the block sees it after clamping.
   int unsigned shape_rows = ROWS_RESET;
   int unsigned shape_cols = COLS_RESET;

   // When set, neither side idles, so the block runs at its own pace.
   bit          steady_flow;

   int unsigned stimulus_items;
   int unsigned loads_sent;
   int unsigned queries_sent;
   int unsigned restarts_sent;
   int unsigned shapes_used;
   int unsigned stall_cycles;

   sat_req_if req_chan ();
   sat_rsp_if rsp_chan ();

   summed_area_table u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   summed_area_table_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .results_pending  (results_pending),
      .results_checked  (results_checked)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle spans are mostly zero or short; now and then a long one appears.
   function automatic int unsigned idle_span();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic int unsigned extent_of(logic [CFG_BITS-1:0] raw, int unsigned limit);
      if (raw == '0) return 1;
      return (32'(raw) > limit) ? limit : 32'(raw);
   endfunction

   // Elements lean towards the extremes so that the 44-bit sums get pushed hard.
   function automatic logic [ELEMENT_BITS-1:0] random_element();
      case ($urandom_range(0, 19))
         0:       return {1'b1, {(ELEMENT_BITS-1){1'b0}}};
         1:       return {1'b0, {(ELEMENT_BITS-1){1'b1}}};
         2:       return '1;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // Every field random, so that fields a command ignores still toggle.
   function automatic area_request_type noise_request();
      area_request_type rq;
      rq.cmd        = CMD_BITS'($urandom_range(0, 3));
      rq.element    = $urandom;
      rq.top_row    = CORNER_BITS'($urandom_range(0, 63));
      rq.left_col   = CORNER_BITS'($urandom_range(0, 63));
      rq.bottom_row = CORNER_BITS'($urandom_range(0, 63));
      rq.right_col  = CORNER_BITS'($urandom_range(0, 63));
      return rq;
   endfunction

   // Most queries have well-formed corners inside the current shape; a few
   // cover the whole table, and the rest keep their random (mostly bad) corners.
   function automatic area_request_type region_request();
      area_request_type rq;
      int unsigned      pick;
      int unsigned      first;
      rq     = noise_request();
      rq.cmd = CMD_QUERY;
      pick   = $urandom_range(0, 99);
      if (pick < 80) begin
         first         = $urandom_range(0, shape_rows - 1);
         rq.top_row    = CORNER_BITS'(first);
         rq.bottom_row = CORNER_BITS'($urandom_range(first, shape_rows - 1));
         first         = $urandom_range(0, shape_cols - 1);
         rq.left_col   = CORNER_BITS'(first);
         rq.right_col  = CORNER_BITS'($urandom_range(first, shape_cols - 1));
      end else if (pick < 88) begin
         rq.top_row    = '0;
         rq.left_col   = '0;
         rq.bottom_row = CORNER_BITS'(shape_rows - 1);
         rq.right_col  = CORNER_BITS'(shape_cols - 1);
      end
      return rq;
   endfunction

   // Presents one request and returns in the time step of its transfer, so a
   // following call can keep valid high without lowering it in between.
   task automatic send_request(input area_request_type rq);
      int unsigned gap;
      gap = steady_flow ? 0 : idle_span();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= rq.cmd;
      req_chan.element    <= rq.element;
      req_chan.top_row    <= rq.top_row;
      req_chan.left_col   <= rq.left_col;
      req_chan.bottom_row <= rq.bottom_row;
      req_chan.right_col  <= rq.right_col;
      do @(posedge clock); while (!req_chan.ready);
      case (rq.cmd)
         CMD_LOAD:    loads_sent++;
         CMD_QUERY:   queries_sent++;
         CMD_RESTART: restarts_sent++;
         default: ;
      endcase
      // The unused command is merely ignored, so it does not count as work.
      if (rq.cmd != CMD_UNUSED) stimulus_items++;
   endtask

   task automatic load_element(input logic [ELEMENT_BITS-1:0] value);
      area_request_type rq;
      rq         = noise_request();
      rq.cmd     = CMD_LOAD;
      rq.element = value;
      send_request(rq);
   endtask

   task automatic ask_region(input int unsigned top_row, left_col, bottom_row, right_col);
      area_request_type rq;
      rq            = noise_request();
      rq.cmd        = CMD_QUERY;
      rq.top_row    = CORNER_BITS'(top_row);
      rq.left_col   = CORNER_BITS'(left_col);
      rq.bottom_row = CORNER_BITS'(bottom_row);
      rq.right_col  = CORNER_BITS'(right_col);
      send_request(rq);
   endtask

   task automatic send_command(input logic [CMD_BITS-1:0] cmd);
      area_request_type rq;
      rq     = noise_request();
      rq.cmd = cmd;
      send_request(rq);
   endtask

   // Registers change only with the block idle: every response has been
   // transferred, and a few more cycles have passed for good measure. The
   // first wait moves past the step of the last transfer, so that the
   // checker's count of waiting results is already up to date.
   task automatic set_shape(input logic [CFG_BITS-1:0] rows_raw, cols_raw);
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= REG_ROWS_IN_USE;
      csr_write_data   <= rows_raw;
      @(posedge clock);
      csr_index        <= REG_COLS_IN_USE;
      csr_write_data   <= cols_raw;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shape_rows = extent_of(rows_raw, MAX_ROWS);
      shape_cols = extent_of(cols_raw, MAX_COLS);
      shapes_used++;
   endtask

   // Loads a whole table. Now and then a query, the unused command or a
   // restart breaks into the stream; after a restart the load begins again.
   task automatic fill_table();
      int unsigned loaded;
      loaded = 0;
      while (loaded < shape_rows * shape_cols) begin
         case ($urandom_range(0, 199))
            0: begin
               send_command(CMD_RESTART);
               loaded = 0;
            end
            1, 2: send_request(region_request());
            3:    send_command(CMD_UNUSED);
            default: begin
               load_element(random_element());
               loaded++;
            end
         endcase
      end
   endtask

   // Short directed opening: incomplete table, the unused command, extreme
   // elements on a 2x2 table, every kind of bad corner, a load into a full
   // table, a restart, and register values of zero treated as one.
   task automatic directed_checks();
      ask_region(0, 0, 0, 0);
      send_command(CMD_UNUSED);
      load_element({1'b0, {(ELEMENT_BITS-1){1'b1}}});
      send_command(CMD_RESTART);

      set_shape(2, 2);
      load_element({1'b0, {(ELEMENT_BITS-1){1'b1}}});
      load_element({1'b0, {(ELEMENT_BITS-1){1'b1}}});
      load_element({1'b1, {(ELEMENT_BITS-1){1'b0}}});
      load_element({1'b1, {(ELEMENT_BITS-1){1'b0}}});
      ask_region(0, 0, 1, 1);
      ask_region(1, 1, 1, 1);
      ask_region(0, 1, 1, 1);
      ask_region(1, 0, 0, 0);      // top below bottom
      ask_region(0, 1, 0, 0);      // left right of right
      ask_region(0, 0, 2, 0);      // bottom outside the table
      ask_region(0, 0, 0, 2);      // right outside the table
      ask_region(63, 63, 63, 63);
      load_element(random_element());
      send_command(CMD_UNUSED);
      send_command(CMD_RESTART);
      ask_region(0, 0, 0, 0);
      load_element('1);

      set_shape(0, 0);
      load_element(1);
      ask_region(0, 0, 0, 0);
      ask_region(0, 0, 0, 1);
   endtask

   // One random phase: pick a shape, load it once or twice, and query it.
   // Most shapes are small; a few reach the 64-row or 64-column limit, or
   // use register values past the limit, paired with a narrow other side.
   task automatic shape_phase(input int unsigned phase);
      logic [CFG_BITS-1:0] rows_raw;
      logic [CFG_BITS-1:0] cols_raw;
      int unsigned         passes;
      rows_raw = CFG_BITS'($urandom_range(1, 6));
      cols_raw = CFG_BITS'($urandom_range(1, 6));
      case (phase)
         3:  begin rows_raw = CFG_BITS'(127); cols_raw = CFG_BITS'($urandom_range(1, 2)); end
         6:  begin cols_raw = CFG_BITS'(64);  rows_raw = CFG_BITS'($urandom_range(1, 2)); end
         11: begin rows_raw = CFG_BITS'(64);  cols_raw = CFG_BITS'($urandom_range(1, 2)); end
         14: begin cols_raw = CFG_BITS'(127); rows_raw = CFG_BITS'($urandom_range(1, 2)); end
         default: begin
            case ($urandom_range(0, 15))
               0: rows_raw = '0;
               1: cols_raw = '0;
               2: begin
                  rows_raw = CFG_BITS'($urandom_range(64, 127));
                  cols_raw = CFG_BITS'($urandom_range(0, 2));
               end
               3: begin
                  cols_raw = CFG_BITS'($urandom_range(64, 127));
                  rows_raw = CFG_BITS'($urandom_range(0, 2));
               end
               4: begin
                  rows_raw = CFG_BITS'($urandom_range(8, 12));
                  cols_raw = CFG_BITS'($urandom_range(8, 12));
               end
               default: ;
            endcase
         end
      endcase
      set_shape(rows_raw, cols_raw);
      steady_flow = ($urandom_range(0, 4) == 0);
      passes      = ($urandom_range(0, 3) == 0) ? 2 : 1;
      for (int unsigned pass = 0; pass < passes; pass++) begin
         // A second pass overwrites the old table after a restart.
         if (pass != 0) send_command(CMD_RESTART);
         fill_table();
         repeat ($urandom_range(6, 20)) begin
            case ($urandom_range(0, 19))
               0:       load_element(random_element());
               1:       send_command(CMD_UNUSED);
               default: send_request(region_request());
            endcase
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin : stimulus
      int unsigned phase;
      int unsigned directed_items;
      req_chan.valid      <= 1'b0;
      req_chan.cmd        <= CMD_LOAD;
      req_chan.element    <= '0;
      req_chan.top_row    <= '0;
      req_chan.left_col   <= '0;
      req_chan.bottom_row <= '0;
      req_chan.right_col  <= '0;
      csr_write_enable    <= 1'b0;
      csr_index           <= REG_ROWS_IN_USE;
      csr_write_data      <= '0;
      reset               <= 1'b1;
      steady_flow          = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      directed_checks();
      directed_items = stimulus_items;

      phase = 0;
      while (stimulus_items - directed_items < RANDOM_ITEMS) begin
         shape_phase(phase);
         phase++;
      end

      // Wait for every outstanding response, then give any stray response
      // time to turn up before the verdict.
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d loads, %0d region queries, %0d restarts)",
               stimulus_items, loads_sent, queries_sent, restarts_sent);
      $display("over %0d table shapes; %0d responses compared, %0d mismatching.",
               shapes_used, results_checked, error_count);
      if (error_count == 0)
         $display("[summed_area_table] OK");
      else
         $display("[summed_area_table] ERROR");
      $finish;
   end

   // Response-side back-pressure: stalls of random length between bursts of
   // readiness, switched off during the steady phases.
   initial begin : response_stalls
      int unsigned span;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         span = steady_flow ? 0 : idle_span();
         if (span != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (span) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Watchdog: too many cycles in a row without any transfer means a hang.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("No transfer for %0d cycles; %0d responses still outstanding.",
                     stall_cycles, results_pending);
            $display("[summed_area_table] ERROR");
            $finish;
         end
      end
   end

endmodule

// File: sim.f
+incdir+src
src/sat_pkg.sv
src/sat_req_if.sv
src/sat_rsp_if.sv
src/sat_table.sv
src/sat_seq.sv
src/summed_area_table.sv
sim/summed_area_table_checker.sv
sim/summed_area_table_tb.sv
